>>> src/gregorian_date_adder_core_macros.svh
// Assertion helpers shared by the date adder modules.
// Both forms expect signals named aclk and aresetn in the using module.
`ifndef GREGORIAN_DATE_ADDER_CORE_MACROS_SVH
`define GREGORIAN_DATE_ADDER_CORE_MACROS_SVH
`ifndef SYNTH
`define GDA_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("date adder assertion failed");
`define GDA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("date adder assertion failed");
`else
`define GDA_ASSERT(label, prop)
`define GDA_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> src/gda_pkg.sv
package gda_pkg;

    localparam int DAY_W   = 17;
    localparam int MONTH_W = 4;
    localparam int REM_W   = 9;
    localparam int QM_W    = 9;
    localparam int X400_W  = 17;
    localparam int QY_W    = 8;

    localparam logic [4:0]         DAY_MAX         = 5'd31;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR       = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN       = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP       = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV       = 4'd11;

    // floor(x / 12) equals (x * 2731) >> 15 for every x below 8192.
    localparam logic [11:0]        RECIP_12       = 12'd2731;
    localparam int                 RECIP_12_SHIFT = 15;
    // floor(x / 25) equals (x * 5243) >> 17 for every x below 8192.
    localparam logic [12:0]        RECIP_25       = 13'd5243;
    localparam int                 RECIP_25_SHIFT = 17;
    localparam logic [X400_W-1:0]  DIV_YEARS      = 17'd400;

    localparam logic [REM_W-1:0]   CENTURY_1    = 9'd100;
    localparam logic [REM_W-1:0]   CENTURY_2    = 9'd200;
    localparam logic [REM_W-1:0]   CENTURY_3    = 9'd300;
    localparam logic [REM_W-1:0]   CYCLE_LAST   = 9'd399;

    localparam logic [4:0] LEN_31 = 5'd31;
    localparam logic [4:0] LEN_30 = 5'd30;
    localparam logic [4:0] LEN_29 = 5'd29;
    localparam logic [4:0] LEN_28 = 5'd28;

    typedef struct packed {
        logic capture;
        logic day_step;
        logic mdiv_init;
        logic month_apply;
        logic rdiv_init;
        logic div_step;
        logic r400_save;
    } gda_cmd_t;

    typedef struct packed {
        logic day_fits;
    } gda_status_t;

    function automatic logic [4:0] month_length(input logic [MONTH_W-1:0] month,
                                                input logic leap);
        logic [4:0] len;
        len = LEN_31;
        if (month == MONTH_FEB) begin
            len = leap ? LEN_29 : LEN_28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = LEN_30;
        end
        return len;
    endfunction

endpackage

>>> src/gda_datapath.sv
module gda_datapath #(
    parameter int YEAR_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gda_pkg::gda_cmd_t      cmd,
    output gda_pkg::gda_status_t   status,
    input  logic                   s_kind,
    input  logic [15:0]            s_day_arg,
    input  logic [11:0]            s_month_arg,
    input  logic [15:0]            s_year_arg,
    output logic [4:0]             m_day_out,
    output logic [3:0]             m_month_out,
    output logic [15:0]            m_year_out,
    output logic                   m_year_overflow
);

    localparam int SUMW = ((YEAR_BITS > 17) ? YEAR_BITS : 17) + 1;
    localparam longint unsigned YEAR_MAX_L = (64'd1 << YEAR_BITS) - 64'd1;
    localparam logic [gda_pkg::REM_W-1:0] R400_SAT = gda_pkg::REM_W'(YEAR_MAX_L % 64'd400);

    logic [gda_pkg::DAY_W-1:0]   day_reg;
    logic [gda_pkg::MONTH_W-1:0] month_reg;
    logic [YEAR_BITS-1:0]        year_reg;
    logic [gda_pkg::REM_W-1:0]   r400_reg;
    logic                        ovf_reg;
    logic [11:0]                 m_arg_reg;
    logic [15:0]                 y_arg_reg;

    logic [gda_pkg::QM_W-1:0]    quo_reg;
    logic [gda_pkg::X400_W-1:0]  x_reg;
    logic [gda_pkg::QY_W-1:0]    q400_reg;

    logic                          leap;
    logic [4:0]                    mlen;
    logic [SUMW-1:0]               year_sum;
    logic [SUMW-1:0]               load_year;
    logic                          load_year_ok;
    logic [12:0]                   month_total;
    logic [24:0]                   month_prod;
    logic [gda_pkg::QM_W-1:0]      month_quo;
    logic [12:0]                   month_rem;
    logic [gda_pkg::X400_W-1:0]    r400_sum;
    logic [25:0]                   year_prod;
    logic [gda_pkg::QY_W-1:0]      year_quo;
    logic [gda_pkg::X400_W-1:0]    r400_rem;

    // Year mod 400 is kept beside the year, so the leap test needs no division.
    assign leap = (year_reg[1:0] == 2'b00) &&
                  (r400_reg != gda_pkg::CENTURY_1) &&
                  (r400_reg != gda_pkg::CENTURY_2) &&
                  (r400_reg != gda_pkg::CENTURY_3);
    assign mlen = gda_pkg::month_length(month_reg, leap);

    assign year_sum     = SUMW'(year_reg) + SUMW'(quo_reg) + SUMW'(y_arg_reg);
    assign load_year    = SUMW'(s_year_arg);
    assign load_year_ok = (s_year_arg != 16'd0) && ((load_year >> YEAR_BITS) == '0);
    assign month_total  = 13'(month_reg) - 13'd1 + 13'(m_arg_reg);

    assign month_prod = 25'(month_total) * 25'(gda_pkg::RECIP_12);
    assign month_quo  = gda_pkg::QM_W'(month_prod >> gda_pkg::RECIP_12_SHIFT);
    assign month_rem  = month_total - 13'(quo_reg) * 13'(gda_pkg::MONTHS_PER_YEAR);

    // The new year mod 400 follows from the old remainder plus what was added.
    // x / 400 is taken as (x / 16) / 25.
    assign r400_sum  = gda_pkg::X400_W'(r400_reg) + gda_pkg::X400_W'(quo_reg) +
                       gda_pkg::X400_W'(y_arg_reg);
    assign year_prod = 26'(x_reg[gda_pkg::X400_W-1:4]) * 26'(gda_pkg::RECIP_25);
    assign year_quo  = gda_pkg::QY_W'(year_prod >> gda_pkg::RECIP_25_SHIFT);
    assign r400_rem  = x_reg - gda_pkg::X400_W'(q400_reg) * gda_pkg::DIV_YEARS;

    assign status.day_fits = (day_reg <= gda_pkg::DAY_W'(mlen));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= gda_pkg::DAY_W'(1);
            month_reg <= gda_pkg::MONTH_W'(1);
            year_reg  <= YEAR_BITS'(1);
            r400_reg  <= gda_pkg::REM_W'(1);
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                ovf_reg <= 1'b0;
                if (!s_kind) begin
                    if (s_day_arg != 16'd0 && s_day_arg <= 16'(gda_pkg::DAY_MAX)) begin
                        day_reg <= gda_pkg::DAY_W'(s_day_arg);
                    end
                    if (s_month_arg != 12'd0 &&
                        s_month_arg <= 12'(gda_pkg::MONTHS_PER_YEAR)) begin
                        month_reg <= s_month_arg[gda_pkg::MONTH_W-1:0];
                    end
                    // A loaded year reaches the remainder through y_arg_reg.
                    if (load_year_ok) begin
                        year_reg <= YEAR_BITS'(s_year_arg);
                        r400_reg <= '0;
                    end
                end else begin
                    day_reg <= day_reg + gda_pkg::DAY_W'(s_day_arg);
                end
            end
            if (cmd.day_step) begin
                day_reg <= day_reg - gda_pkg::DAY_W'(mlen);
                if (month_reg == gda_pkg::MONTHS_PER_YEAR) begin
                    month_reg <= gda_pkg::MONTH_W'(1);
                    if (year_reg == {YEAR_BITS{1'b1}}) begin
                        ovf_reg <= 1'b1;
                    end else begin
                        year_reg <= year_reg + YEAR_BITS'(1);
                        r400_reg <= (r400_reg == gda_pkg::CYCLE_LAST) ? '0
                                    : r400_reg + gda_pkg::REM_W'(1);
                    end
                end else begin
                    month_reg <= month_reg + gda_pkg::MONTH_W'(1);
                end
            end
            if (cmd.month_apply) begin
                month_reg <= month_rem[gda_pkg::MONTH_W-1:0] + gda_pkg::MONTH_W'(1);
                if ((year_sum >> YEAR_BITS) != '0) begin
                    year_reg <= {YEAR_BITS{1'b1}};
                    ovf_reg  <= 1'b1;
                end else begin
                    year_reg <= year_sum[YEAR_BITS-1:0];
                end
            end
            if (cmd.r400_save) begin
                r400_reg <= (year_reg == {YEAR_BITS{1'b1}}) ? R400_SAT
                            : r400_rem[gda_pkg::REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_arg_reg <= s_month_arg;
            y_arg_reg <= (s_kind || load_year_ok) ? s_year_arg : 16'd0;
            quo_reg   <= '0;
        end
        if (cmd.mdiv_init) begin
            quo_reg <= month_quo;
        end
        if (cmd.rdiv_init) begin
            x_reg <= r400_sum;
        end
        if (cmd.div_step) begin
            q400_reg <= year_quo;
        end
    end

    assign m_day_out       = day_reg[4:0];
    assign m_month_out     = month_reg;
    assign m_year_out      = 16'(year_reg);
    assign m_year_overflow = ovf_reg;

`include "gregorian_date_adder_core_macros.svh"

    `GDA_ASSERT(a_month_range, month_reg != '0 && month_reg <= gda_pkg::MONTHS_PER_YEAR)
    `GDA_ASSERT(a_r400_range, r400_reg <= gda_pkg::CYCLE_LAST)
    `GDA_ASSERT_NEXT(a_day_shrinks, cmd.day_step, day_reg < $past(day_reg))

endmodule

>>> src/gda_ctrl.sv
module gda_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gda_pkg::gda_cmd_t     cmd,
    input  gda_pkg::gda_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MAPPLY,
        ST_RINIT,
        ST_RDIV,
        ST_RSAVE,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = s_kind ? ST_WALK : ST_RINIT;
                end
            end
            ST_WALK: begin
                if (status.day_fits) begin
                    cmd.mdiv_init = 1'b1;
                    state_next    = ST_MAPPLY;
                end else begin
                    cmd.day_step = 1'b1;
                end
            end
            ST_MAPPLY: begin
                cmd.month_apply = 1'b1;
                state_next      = ST_RINIT;
            end
            ST_RINIT: begin
                cmd.rdiv_init = 1'b1;
                state_next    = ST_RDIV;
            end
            ST_RDIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_RSAVE;
            end
            ST_RSAVE: begin
                cmd.r400_save = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

`include "gregorian_date_adder_core_macros.svh"

    `GDA_ASSERT(a_one_side, !(s_ready && m_valid))
    `GDA_ASSERT_NEXT(a_busy_after_beat, s_valid && s_ready, !s_ready && !m_valid)
    `GDA_ASSERT_NEXT(a_walk_ends, state_reg == ST_WALK && status.day_fits, state_reg == ST_MAPPLY)

endmodule

>>> src/gregorian_date_adder_core.sv
// Gregorian date adder: holds one calendar date and returns it after every input beat.
// Input channel s_*: kind 0 loads each in-range part of day/month/year; kind 1 adds
// days, then months, then years to the held date, with month and leap-year carries.
// Result channel m_*: day, month, low 16 bits of the year, and a flag that is set when
// the year was held at its maximum during this beat's addition.
// One beat is processed at a time:
//   load beat: states ST_RINIT, ST_RDIV and ST_RSAVE, then m_valid rises;
//   add beat:  ST_WALK steps over one month boundary at a time, then ST_MAPPLY,
//              ST_RINIT, ST_RDIV and ST_RSAVE, then m_valid rises.
// The day walk steps one month per cycle. The month carry and the year mod 400 that
// feeds the leap test are each found by a multiply with a constant reciprocal.
// s_ready is high again in the cycle after the result beat is taken.
// A stalled receiver simply holds the result; no new beat is accepted meanwhile.
// Synchronous active-low reset sets the date to day 1, month 1, year 1 and drops
// both valid and the result flag.
module gregorian_date_adder_core #(
    parameter int YEAR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_day_arg,
    input  logic [11:0] s_month_arg,
    input  logic [15:0] s_year_arg,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_day_out,
    output logic [3:0]  m_month_out,
    output logic [15:0] m_year_out,
    output logic        m_year_overflow
);

    gda_pkg::gda_cmd_t    cmd;
    gda_pkg::gda_status_t status;

    gda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    gda_datapath #(
        .YEAR_BITS (YEAR_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_kind          (s_kind),
        .s_day_arg       (s_day_arg),
        .s_month_arg     (s_month_arg),
        .s_year_arg      (s_year_arg),
        .m_day_out       (m_day_out),
        .m_month_out     (m_month_out),
        .m_year_out      (m_year_out),
        .m_year_overflow (m_year_overflow)
    );

endmodule
